// ----- design/flwrl_pkg.sv -----
// ----------------------------------------------------------------------------
// flwrl_pkg
// Shared types and constants of the per-flow fixed-window rate limiter.
// ----------------------------------------------------------------------------
package flwrl_pkg;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_QUERY   = 2'd1,
        KIND_TICK    = 2'd2,
        KIND_SWEEP   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_REQUESTS  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 4'd1;

    localparam logic [15:0] MAX_REQUESTS_RESET  = 16'd100;
    localparam logic [15:0] WINDOW_LENGTH_RESET = 16'd60;

    // One table entry as stored in the flow memory.
    typedef struct packed {
        logic        valid;
        logic [31:0] window_start;
        logic [15:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic        allowed;
        logic        found;
        logic [15:0] count;
        logic [15:0] reset_time;
    } result_t;

endpackage

// ----- design/flwrl_ram.sv -----
// ----------------------------------------------------------------------------
// flwrl_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module flwrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/flwrl_update.sv -----
// ----------------------------------------------------------------------------
// flwrl_update
// Read-modify-write decision for one table entry: request admission,
// status query and expiry check for the cleanup sweep.
// ----------------------------------------------------------------------------
module flwrl_update (
    input  flwrl_pkg::kind_t   kind,
    input  logic               in_table,
    input  flwrl_pkg::entry_t  entry,
    input  logic [31:0]        now_seconds,
    input  logic [15:0]        max_requests,
    input  logic [15:0]        window_length,
    output logic               write,
    output flwrl_pkg::entry_t  new_entry,
    output flwrl_pkg::result_t result
);

    logic [31:0] elapsed;
    logic        over;
    logic        live;

    assign elapsed = now_seconds - entry.window_start;
    assign over    = elapsed >= {16'd0, window_length};
    assign live    = in_table && entry.valid;

    always_comb
    begin
        write     = 1'b0;
        new_entry = entry;
        result    = '0;
        case (kind)
            flwrl_pkg::KIND_REQUEST:
            begin
                if (in_table)
                begin
                    if (!entry.valid || over)
                    begin
                        write                  = 1'b1;
                        new_entry.valid        = 1'b1;
                        new_entry.window_start = now_seconds;
                        new_entry.count        = 16'd1;
                        result.allowed         = 1'b1;
                    end
                    else if (entry.count < max_requests)
                    begin
                        write           = 1'b1;
                        new_entry.count = entry.count + 16'd1;
                        result.allowed  = 1'b1;
                    end
                end
            end
            flwrl_pkg::KIND_QUERY:
            begin
                if (live)
                begin
                    result.found = 1'b1;
                    if (!over)
                    begin
                        result.count      = entry.count;
                        result.reset_time = window_length - elapsed[15:0];
                    end
                end
                else
                begin
                    result.reset_time = window_length;
                end
            end
            flwrl_pkg::KIND_SWEEP:
            begin
                if (entry.valid && over)
                begin
                    write           = 1'b1;
                    new_entry.valid = 1'b0;
                end
            end
            default:
            begin
                write = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/per_flow_fixed_window_rate_limiter.sv -----
// ----------------------------------------------------------------------------
// per_flow_fixed_window_rate_limiter
// Per-flow fixed-window request limiter over a flow table held in one
// synchronous RAM, with a seconds counter, status queries and a cleanup sweep.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  -------   ----------------   ------------------------------------------
//  command   start / busy       kind, flow_id
//  result    done (strobe)      allowed, found, count, reset_time
//  config    cfg_valid/ready    cfg_index, cfg_data
//
// For a request or status query the entry is read from the flow RAM in the
// accept cycle and checked in the next, where a request writes it back if it
// changed; the result strobe follows in the cycle after. A tick advances the
// seconds counter and strobes done. A cleanup sweep walks the RAM one entry
// per cycle. After reset a clearing pass over every entry runs with busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module per_flow_fixed_window_rate_limiter #(
    parameter int FLOWS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        kind,
    input  logic [7:0]                        flow_id,
    output logic                              done,
    output logic                              allowed,
    output logic                              found,
    output logic [15:0]                       count,
    output logic [15:0]                       reset_time,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [flwrl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                       cfg_data
);

    localparam int IDX_W = $clog2(FLOWS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOWS - 1);

    flwrl_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;      // write address of pending entry
    logic [IDX_W-1:0]   scan_reg, scan_next;      // clear and sweep pointer
    logic               pend_reg, pend_next;      // sweep read data is in flight
    flwrl_pkg::kind_t   kind_reg, kind_next;
    logic               in_table_reg, in_table_next;
    logic [31:0]        now_reg, now_next;
    logic [15:0]        max_reg, max_next;
    logic [15:0]        win_reg, win_next;
    logic               done_reg, done_next;
    flwrl_pkg::result_t result_reg, result_next;

    logic               accept;
    flwrl_pkg::kind_t   kind_in;
    logic               flow_in_table;
    logic [IDX_W-1:0]   flow_idx;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    flwrl_pkg::entry_t       ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [flwrl_pkg::ENTRY_W-1:0] ram_rdata;

    flwrl_pkg::kind_t   upd_kind;
    logic               upd_write;
    flwrl_pkg::entry_t  upd_entry;
    flwrl_pkg::result_t upd_result;

    assign kind_in       = flwrl_pkg::kind_t'(kind);
    assign flow_in_table = 32'(flow_id) < FLOWS;
    assign flow_idx      = IDX_W'(32'(flow_id));
    assign accept        = start && (state_reg == flwrl_pkg::ST_IDLE);

    // The flow table: valid bit, window start and count per flow.
    flwrl_ram #(
        .WIDTH (flwrl_pkg::ENTRY_W),
        .DEPTH (FLOWS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // In the lookup state the decision logic handles the item latched at accept
    // time; in every other state it checks expiry for the sweep.
    assign upd_kind = (state_reg == flwrl_pkg::ST_LOOKUP) ? kind_reg : flwrl_pkg::KIND_SWEEP;

    flwrl_update u_update (
        .kind          (upd_kind),
        .in_table      (in_table_reg),
        .entry         (flwrl_pkg::entry_t'(ram_rdata)),
        .now_seconds   (now_reg),
        .max_requests  (max_reg),
        .window_length (win_reg),
        .write         (upd_write),
        .new_entry     (upd_entry),
        .result        (upd_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= flwrl_pkg::ST_CLEAR;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
            now_reg      <= '0;
            max_reg      <= flwrl_pkg::MAX_REQUESTS_RESET;
            win_reg      <= flwrl_pkg::WINDOW_LENGTH_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            pend_reg     <= pend_next;
            now_reg      <= now_next;
            max_reg      <= max_next;
            win_reg      <= win_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        kind_reg     <= kind_next;
        in_table_reg <= in_table_next;
        result_reg   <= result_next;
    end

    // Configuration writes of zero leave the register unchanged.
    always_comb
    begin
        max_next = max_reg;
        win_next = win_reg;
        if (cfg_valid && cfg_ready && (cfg_data != 16'd0))
        begin
            if (cfg_index == flwrl_pkg::REG_MAX_REQUESTS)
            begin
                max_next = cfg_data;
            end
            else if (cfg_index == flwrl_pkg::REG_WINDOW_LENGTH)
            begin
                win_next = cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        kind_next     = kind_reg;
        in_table_next = in_table_reg;
        now_next      = now_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = upd_entry;
        ram_raddr     = scan_reg;

        unique case (state_reg)
            flwrl_pkg::ST_CLEAR:
            begin
                // Clearing pass: invalidate every entry once after reset.
                ram_we    = 1'b1;
                ram_waddr = scan_reg;
                ram_wdata = '0;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == LAST_IDX)
                begin
                    scan_next  = '0;
                    state_next = flwrl_pkg::ST_IDLE;
                end
            end
            flwrl_pkg::ST_IDLE:
            begin
                ram_raddr = flow_idx;
                if (accept)
                begin
                    kind_next     = kind_in;
                    in_table_next = flow_in_table;
                    addr_next     = flow_idx;
                    unique case (kind_in)
                        flwrl_pkg::KIND_REQUEST, flwrl_pkg::KIND_QUERY:
                        begin
                            state_next = flwrl_pkg::ST_LOOKUP;
                        end
                        flwrl_pkg::KIND_TICK:
                        begin
                            now_next    = now_reg + 32'd1;
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                        flwrl_pkg::KIND_SWEEP:
                        begin
                            scan_next  = '0;
                            state_next = flwrl_pkg::ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = flwrl_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            flwrl_pkg::ST_LOOKUP:
            begin
                ram_we      = upd_write;
                done_next   = 1'b1;
                result_next = upd_result;
                state_next  = flwrl_pkg::ST_IDLE;
            end
            flwrl_pkg::ST_SWEEP:
            begin
                // Read entry scan_reg while the previously read entry, now at the
                // RAM output, is checked and, if expired, written back invalid.
                ram_raddr     = scan_reg;
                ram_we        = pend_reg && upd_write;
                pend_next     = 1'b1;
                addr_next     = scan_reg;
                in_table_next = 1'b1;
                scan_next     = scan_reg + 1'b1;
                if (scan_reg == LAST_IDX)
                begin
                    scan_next  = '0;
                    state_next = flwrl_pkg::ST_DRAIN;
                end
            end
            flwrl_pkg::ST_DRAIN:
            begin
                ram_we      = upd_write;
                done_next   = 1'b1;
                result_next = '0;
                state_next  = flwrl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = flwrl_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy       = state_reg != flwrl_pkg::ST_IDLE;
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign allowed    = result_reg.allowed;
    assign found      = result_reg.found;
    assign count      = result_reg.count;
    assign reset_time = result_reg.reset_time;

endmodule

// ----- design/flwrl_checker.sv -----
// ----------------------------------------------------------------------------
// flwrl_checker
// Port-level checks of the rate limiter's item timing and result contents.
// ----------------------------------------------------------------------------
module flwrl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  kind,
    input logic        done,
    input logic        allowed,
    input logic        found,
    input logic [15:0] count,
    input logic [15:0] reset_time
);

    logic acc_lookup;
    logic acc_tick;

    assign acc_lookup = start && !busy &&
                        (kind == flwrl_pkg::KIND_REQUEST || kind == flwrl_pkg::KIND_QUERY);
    assign acc_tick   = start && !busy && (kind == flwrl_pkg::KIND_TICK);

    // A request or query occupies the block and then reports a result.
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        acc_lookup |=> busy)
        else $error("busy not raised after request or query");

    a_lookup_done: assert property (@(posedge clk) disable iff (!rst_n)
        acc_lookup |-> ##2 done)
        else $error("request or query result missing");

    a_tick_done: assert property (@(posedge clk) disable iff (!rst_n)
        acc_tick |=> done)
        else $error("tick result missing");

    // Only requests admit, and they report no query fields.
    a_allowed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && allowed |-> !found && count == 16'd0 && reset_time == 16'd0)
        else $error("admitted request carries query fields");

    // A live entry has a nonzero count and time left; an expired one has neither.
    a_found_pair: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> ((count == 16'd0) == (reset_time == 16'd0)))
        else $error("query count and time left disagree");

endmodule

bind per_flow_fixed_window_rate_limiter flwrl_checker u_flwrl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .done       (done),
    .allowed    (allowed),
    .found      (found),
    .count      (count),
    .reset_time (reset_time)
);
